// ----- rtl/assert_macros.svh -----
// assertion helpers, sampled on clk, off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RMQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rmq assertion failed");

`define RMQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmq implication failed");

`endif

// ----- rtl/rmq_pkg.sv -----
package rmq_pkg;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_COL0  = 2'd1,
    BR_COL1  = 2'd2,
    BR_COL2  = 2'd3
  } branch_t;

  localparam int ELEM_W = 16;
  localparam int NUM_W  = 17;
  localparam int THR_W  = 15;
  localparam int N_ELEM = 9;
  localparam int IN_W   = N_ELEM * ELEM_W;
  localparam int OUT_W  = 4 * ELEM_W;

endpackage

// ----- rtl/rotation_matrix_to_quaternion_core.sv -----
// Rotation block to quaternion converter (Shepperd method), signed fixed point.
// in_*  : one 3x3 row-major rotation block per item; tdata holds r00 in the
//         lowest 16 bits up to r22 in bits 143:128.
// out_* : one quaternion per item; tdata holds x, y, z, w from the lowest bit
//         up, tuser the branch code (0 trace, 1..3 diagonal column).
// cfg_* : writes the trace threshold; one plus the trace must exceed it for
//         the trace path. Always ready; write it only while the block is idle.
// Throughput: one item per cycle while out_tready is high. Path: an item
// passes the classify register, the queue, the bit-per-stage square root of
// root width RW ((AW-1+FRAC_BITS+1)/2), the three bit-per-stage dividers of
// width NW = 17 + FRAC_BITS that follow and the output register, after which
// out_tvalid rises.
// A classify stage feeds a two-entry queue; the back pipeline drains it.
// When out_tready is low the back pipeline holds, the queue fills, then the
// classify stage and in_tready stop. No item is dropped or repeated.
// Synchronous reset clears the threshold to 0 and empties every stage.
`include "assert_macros.svh"

module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rmq_pkg::THR_W-1:0] cfg_data,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [rmq_pkg::IN_W-1:0]  in_tdata,   // r00 r01 r02 r10 r11 r12 r20 r21 r22
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [rmq_pkg::OUT_W-1:0] out_tdata,  // quat_x quat_y quat_z quat_w
  output logic [1:0]                out_tuser   // branch_taken
);
  import rmq_pkg::*;

  localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int PW = AW + 1 + 3 * NUM_W;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [PW-1:0] f_data, b_data;

  rmq_front #(.F(FRAC_BITS), .AW(AW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_data    (f_data)
  );

  rmq_fifo #(.W(PW)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (f_valid),
    .s_ready (f_ready),
    .s_data  (f_data),
    .m_valid (b_valid),
    .m_ready (b_ready),
    .m_data  (b_data)
  );

  rmq_back #(.F(FRAC_BITS), .AW(AW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_data     (b_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // queue room always lets the classify stage take an item
  `RMQ_ASSERT_IMPL(a_front_free, f_ready, in_tready)
  // a stalled output freezes the back pipeline, so nothing leaves the queue
  `RMQ_ASSERT_IMPL(a_no_pop_on_stall, out_tvalid && !out_tready, !b_ready)
  // a full queue that is not popped stops in_tready while the classify stage holds an item
  `RMQ_ASSERT(a_queue_sane, !(b_valid && !f_ready && f_valid && !b_ready) || !in_tready ||
              !f_valid)

endmodule

// ----- rtl/rmq_front.sv -----
module rmq_front #(
  parameter int F  = 14,
  parameter int AW = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rmq_pkg::THR_W-1:0]   cfg_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rmq_pkg::IN_W-1:0]    in_tdata,
  output logic                        q_valid,
  input  logic                        q_ready,
  output logic [AW+3*rmq_pkg::NUM_W:0] q_data
);
  import rmq_pkg::*;

  localparam int PW = AW + 1 + 3 * NUM_W;
  localparam logic signed [AW-1:0] ONE_A = AW'(1) << F;

  logic [THR_W-1:0] thr_r;
  logic             vld_r;
  logic [PW-1:0]    pl_r;
  logic [PW-1:0]    pl_nxt;

  logic signed [ELEM_W-1:0] e [N_ELEM];
  logic signed [AW-1:0]     d00, d11, d22, tr, thr_s, a_s;
  logic        [AW-2:0]     a_u;
  logic signed [NUM_W-1:0]  n0, n1, n2;
  logic signed [NUM_W-1:0]  x01, x02, x10, x12, x20, x21;
  branch_t                  br;

  always_comb begin
    for (int i = 0; i < N_ELEM; i++) begin
      e[i] = in_tdata[i*ELEM_W +: ELEM_W];
    end
    d00   = AW'(e[0]);
    d11   = AW'(e[4]);
    d22   = AW'(e[8]);
    x01   = NUM_W'(e[1]);
    x02   = NUM_W'(e[2]);
    x10   = NUM_W'(e[3]);
    x12   = NUM_W'(e[5]);
    x20   = NUM_W'(e[6]);
    x21   = NUM_W'(e[7]);
    tr    = ONE_A + d00 + d11 + d22;
    thr_s = $signed(AW'(thr_r));
    if (tr > thr_s) begin
      br  = BR_TRACE;
      a_s = tr;
      n0  = x21 - x12;
      n1  = x02 - x20;
      n2  = x10 - x01;
    end else if (d00 > d11 && d00 > d22) begin
      br  = BR_COL0;
      a_s = ONE_A + d00 - d11 - d22;
      n0  = x01 + x10;
      n1  = x02 + x20;
      n2  = x21 - x12;
    end else if (d11 > d22) begin
      br  = BR_COL1;
      a_s = ONE_A + d11 - d00 - d22;
      n0  = x01 + x10;
      n1  = x12 + x21;
      n2  = x02 - x20;
    end else begin
      br  = BR_COL2;
      a_s = ONE_A + d22 - d00 - d11;
      n0  = x02 + x20;
      n1  = x12 + x21;
      n2  = x10 - x01;
    end
    // a negative root argument counts as zero
    a_u    = a_s[AW-1] ? '0 : a_s[AW-2:0];
    pl_nxt = {n2, n1, n0, a_u, br};
  end

  assign cfg_ready = 1'b1;
  assign in_tready = !vld_r || q_ready;
  assign q_valid   = vld_r;
  assign q_data    = pl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      vld_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
      if (in_tready) begin
        vld_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      pl_r <= pl_nxt;
    end
  end

endmodule

// ----- rtl/rmq_fifo.sv -----
module rmq_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_valid,
  output logic         s_ready,
  input  logic [W-1:0] s_data,
  output logic         m_valid,
  input  logic         m_ready,
  output logic [W-1:0] m_data
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         push, pop;

  assign s_ready = (cnt_r != 2'd2);
  assign m_valid = (cnt_r != 2'd0);
  assign m_data  = mem_r[rp_r];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= s_data;
    end
  end

endmodule

// ----- rtl/rmq_back.sv -----
module rmq_back #(
  parameter int F  = 14,
  parameter int AW = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  logic [AW+3*rmq_pkg::NUM_W:0] q_data,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rmq_pkg::OUT_W-1:0]    out_tdata,
  output logic [1:0]                   out_tuser
);
  import rmq_pkg::*;

  localparam int SW   = AW - 1 + F;
  localparam int RW   = (SW + 1) / 2;
  localparam int RADW = 2 * RW;
  localparam int NW   = NUM_W + F;
  localparam int S    = RW + NW;
  localparam logic [NW-1:0] ONE_N = NW'(1) << F;
  localparam logic [RW:0]   ONE_R = (RW+1)'(1) << F;

  logic                    vld_r  [S];
  branch_t                 br_r   [S];
  logic signed [NUM_W-1:0] n_r    [S][3];
  logic [RADW-1:0]         rad_r  [S];
  logic [RW+1:0]           srem_r [S];
  logic [RW-1:0]           root_r [S];
  logic [NW-1:0]           dvd_r  [S][3];
  logic [RW+1:0]           drem_r [S][3];
  logic [NW-1:0]           quo_r  [S][3];

  logic                    vld_nxt  [S];
  branch_t                 br_nxt   [S];
  logic signed [NUM_W-1:0] n_nxt    [S][3];
  logic [RADW-1:0]         rad_nxt  [S];
  logic [RW+1:0]           srem_nxt [S];
  logic [RW-1:0]           root_nxt [S];
  logic [NW-1:0]           dvd_nxt  [S][3];
  logic [RW+1:0]           drem_nxt [S][3];
  logic [NW-1:0]           quo_nxt  [S][3];

  logic                    out_vld_r;
  logic [OUT_W-1:0]        out_data_r, out_data_nxt;
  logic [1:0]              out_br_r;
  logic                    en;

  assign en         = !out_vld_r || out_tready;
  assign q_ready    = en;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_br_r;

  // stage k takes its operands from stage k-1, stage 0 from the queue
  always_comb begin
    logic                    s_vld;
    branch_t                 s_br;
    logic signed [NUM_W-1:0] s_n    [3];
    logic [RADW-1:0]         s_rad;
    logic [RW+1:0]           s_srem;
    logic [RW-1:0]           s_root;
    logic [NW-1:0]           s_dvd  [3];
    logic [RW+1:0]           s_drem [3];
    logic [NW-1:0]           s_quo  [3];
    logic [NUM_W-1:0]        mag;
    logic [RW+3:0]           sq_t, sq_try;
    logic [RW+2:0]           dv_t, dv_d;
    logic                    ge;
    for (int k = 0; k < S; k++) begin
      if (k == 0) begin
        s_vld  = q_valid;
        s_br   = branch_t'(q_data[1:0]);
        s_rad  = RADW'(q_data[AW:2]) << F;
        s_srem = '0;
        s_root = '0;
        for (int j = 0; j < 3; j++) begin
          s_n[j]    = q_data[AW+1+j*NUM_W +: NUM_W];
          s_dvd[j]  = '0;
          s_drem[j] = '0;
          s_quo[j]  = '0;
        end
      end else begin
        s_vld  = vld_r[k-1];
        s_br   = br_r[k-1];
        s_rad  = rad_r[k-1];
        s_srem = srem_r[k-1];
        s_root = root_r[k-1];
        for (int j = 0; j < 3; j++) begin
          s_n[j]    = n_r[k-1][j];
          s_dvd[j]  = dvd_r[k-1][j];
          s_drem[j] = drem_r[k-1][j];
          s_quo[j]  = quo_r[k-1][j];
        end
      end
      vld_nxt[k]  = s_vld;
      br_nxt[k]   = s_br;
      rad_nxt[k]  = s_rad;
      srem_nxt[k] = s_srem;
      root_nxt[k] = s_root;
      for (int j = 0; j < 3; j++) begin
        n_nxt[k][j]    = s_n[j];
        dvd_nxt[k][j]  = s_dvd[j];
        drem_nxt[k][j] = s_drem[j];
        quo_nxt[k][j]  = s_quo[j];
      end
      if (k < RW) begin
        // one root bit per stage
        sq_t        = {s_srem, s_rad[RADW-1 -: 2]};
        sq_try      = (RW+4)'({s_root, 2'b01});
        ge          = (sq_t >= sq_try);
        srem_nxt[k] = ge ? (RW+2)'(sq_t - sq_try) : (RW+2)'(sq_t);
        root_nxt[k] = {s_root[RW-2:0], ge};
        rad_nxt[k]  = s_rad << 2;
      end else begin
        dv_d = (RW+3)'({s_root, 1'b0});
        for (int j = 0; j < 3; j++) begin
          if (k == RW) begin
            mag       = s_n[j][NUM_W-1] ? NUM_W'(-s_n[j]) : NUM_W'(s_n[j]);
            s_dvd[j]  = NW'(mag) << F;
            s_drem[j] = '0;
            s_quo[j]  = '0;
          end
          // one quotient bit per stage on magnitudes
          dv_t           = {s_drem[j], s_dvd[j][NW-1]};
          ge             = (dv_t >= dv_d);
          drem_nxt[k][j] = ge ? (RW+2)'(dv_t - dv_d) : (RW+2)'(dv_t);
          quo_nxt[k][j]  = {s_quo[j][NW-2:0], ge};
          dvd_nxt[k][j]  = s_dvd[j] << 1;
        end
      end
    end
  end

  always_comb begin
    logic [RW:0]      own;
    logic [NW-1:0]    qm;
    logic [ELEM_W-1:0] own_q;
    logic [ELEM_W-1:0] ln [3];
    own   = (RW+1)'(root_r[S-1] >> 1);
    if (own > ONE_R) own = ONE_R;
    own_q = own[ELEM_W-1:0];
    for (int j = 0; j < 3; j++) begin
      qm = quo_r[S-1][j];
      if (qm > ONE_N) qm = ONE_N;
      if (n_r[S-1][j][NUM_W-1]) qm = NW'(-qm);
      ln[j] = (root_r[S-1] == '0) ? '0 : qm[ELEM_W-1:0];
    end
    unique case (br_r[S-1])
      BR_TRACE: out_data_nxt = {own_q, ln[2], ln[1], ln[0]};
      BR_COL0:  out_data_nxt = {ln[2], ln[1], ln[0], own_q};
      BR_COL1:  out_data_nxt = {ln[2], ln[1], own_q, ln[0]};
      BR_COL2:  out_data_nxt = {ln[2], own_q, ln[1], ln[0]};
      default:  out_data_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < S; k++) vld_r[k] <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < S; k++) vld_r[k] <= vld_nxt[k];
      out_vld_r <= vld_r[S-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < S; k++) begin
        br_r[k]   <= br_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        srem_r[k] <= srem_nxt[k];
        root_r[k] <= root_nxt[k];
        for (int j = 0; j < 3; j++) begin
          n_r[k][j]    <= n_nxt[k][j];
          dvd_r[k][j]  <= dvd_nxt[k][j];
          drem_r[k][j] <= drem_nxt[k][j];
          quo_r[k][j]  <= quo_nxt[k][j];
        end
      end
      out_data_r <= out_data_nxt;
      out_br_r   <= br_r[S-1];
    end
  end

endmodule

// ----- test/rmq_checker.sv -----
module rmq_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [rmq_pkg::THR_W-1:0] cfg_data,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [rmq_pkg::IN_W-1:0]  in_tdata,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [rmq_pkg::OUT_W-1:0] out_tdata,
  input  logic [1:0]                out_tuser,
  output int                        fail_count,
  output int                        pending,
  output int                        quat_count,
  output int                        branch_seen [4]
);
  import rmq_pkg::*;

  localparam int FB = 14;
  localparam longint ONE = 64'sd1 << FB;

  typedef struct packed {
    logic [OUT_W-1:0] quat;
    branch_t          br;
  } quat_t;

  quat_t expected_quats[$];
  logic [THR_W-1:0] thr_shadow;

  function automatic longint elem(input logic [IN_W-1:0] d, input int k);
    logic signed [ELEM_W-1:0] v;
    v = d[k*ELEM_W +: ELEM_W];
    return longint'(v);
  endfunction

  function automatic longint int_sqrt(input longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 60;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic logic [ELEM_W-1:0] clamp_one(input longint v);
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    return v[ELEM_W-1:0];
  endfunction

  function automatic longint scaled_div(input longint n, input longint root);
    if (root == 0) return 0;
    return (n * ONE) / (2 * root);  // truncates toward zero
  endfunction

  function automatic quat_t convert_matrix(input logic [IN_W-1:0] d,
                                           input logic [THR_W-1:0] thr);
    longint m[9];
    longint t, a, root;
    longint q[4];
    branch_t br;
    quat_t res;
    for (int k = 0; k < 9; k++) m[k] = elem(d, k);
    t = ONE + m[0] + m[4] + m[8];
    if (t > longint'(thr)) begin
      br = BR_TRACE; a = t;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      br = BR_COL0; a = ONE + m[0] - m[4] - m[8];
    end else if (m[4] > m[8]) begin
      br = BR_COL1; a = ONE + m[4] - m[0] - m[8];
    end else begin
      br = BR_COL2; a = ONE + m[8] - m[0] - m[4];
    end
    if (a < 0) a = 0;
    root = int_sqrt(a * ONE);
    case (br)
      BR_TRACE: begin
        q[0] = scaled_div(m[7] - m[5], root);
        q[1] = scaled_div(m[2] - m[6], root);
        q[2] = scaled_div(m[3] - m[1], root);
        q[3] = root / 2;
      end
      BR_COL0: begin
        q[0] = root / 2;
        q[1] = scaled_div(m[1] + m[3], root);
        q[2] = scaled_div(m[2] + m[6], root);
        q[3] = scaled_div(m[7] - m[5], root);
      end
      BR_COL1: begin
        q[0] = scaled_div(m[1] + m[3], root);
        q[1] = root / 2;
        q[2] = scaled_div(m[5] + m[7], root);
        q[3] = scaled_div(m[2] - m[6], root);
      end
      default: begin
        q[0] = scaled_div(m[2] + m[6], root);
        q[1] = scaled_div(m[5] + m[7], root);
        q[2] = root / 2;
        q[3] = scaled_div(m[3] - m[1], root);
      end
    endcase
    for (int k = 0; k < 4; k++) res.quat[k*ELEM_W +: ELEM_W] = clamp_one(q[k]);
    res.br = br;
    return res;
  endfunction

  assign pending = expected_quats.size();

  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst_n) begin
      thr_shadow <= '0;
      fail_count <= 0;
      quat_count <= 0;
      for (int b = 0; b < 4; b++) branch_seen[b] <= 0;
      expected_quats.delete();
    end else begin
      if (cfg_valid && cfg_ready) thr_shadow <= cfg_data;
      if (in_tvalid && in_tready) expected_quats.push_back(convert_matrix(in_tdata, thr_shadow));
      if (out_tvalid && out_tready) begin
        quat_count <= quat_count + 1;
        if (expected_quats.size() == 0) begin
          if (fail_count < 10) $display("unexpected quaternion %h br %0d", out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_q = expected_quats.pop_front();
          branch_seen[exp_q.br] <= branch_seen[exp_q.br] + 1;
          if (out_tdata !== exp_q.quat || out_tuser !== exp_q.br) begin
            if (fail_count < 10)
              $display("mismatch: exp xyzw %h br %0d, got %h br %0d",
                       exp_q.quat, exp_q.br, out_tdata, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- test/tb_rotation_matrix_to_quaternion_core.sv -----
module tb_rotation_matrix_to_quaternion_core;
  import rmq_pkg::*;

  localparam int LATENCY = 51;
  localparam int WATCHDOG = 4000;
  localparam logic signed [15:0] P1 = 16'sd16384;
  localparam logic signed [15:0] N1 = -16'sd16384;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  int fail_count, pending, quat_count;
  int branch_seen [4];
  int idle_cycles = 0;
  int out_wait = 0;
  int sent = 0;
  bit finishing = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rotation_matrix_to_quaternion_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  rmq_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .fail_count(fail_count), .pending(pending),
    .quat_count(quat_count), .branch_seen(branch_seen)
  );

  // result side: after each item taken, tready may drop for a random stall
  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_wait <= 0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        stall = finishing ? 0 : $urandom_range(0, 3);
        if (stall != 0) begin
          out_tready <= 1'b0;
          out_wait <= stall - 1;
        end
      end
    end else if (out_wait == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_wait <= out_wait - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_valid))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // tvalid stays high into the next item when there is no gap
  task automatic send_matrix(input logic signed [15:0] m [9]);
    int gap;
    logic [IN_W-1:0] d;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int k = 0; k < 9; k++) d[k*16 +: 16] = m[k];
    in_tdata <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain_and_set(input logic [THR_W-1:0] thr);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_data <= thr;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rnd_elem();
    case ($urandom_range(0, 7))
      0: return P1;
      1: return N1;
      2: return 16'($urandom);  // out-of-range noise, all bits
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // a rotation-like matrix: signed permutation with small perturbations
  task automatic rnd_rotation(output logic signed [15:0] m [9]);
    int perm [3];
    int j, tmp;
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        if (perm[r] == c) m[r*3+c] = ($urandom_range(0, 1) ? P1 : N1)
                                     - 16'($signed($urandom_range(0, 6000)) * ($urandom_range(0,1) ? 1 : -1));
        else m[r*3+c] = 16'($signed($urandom_range(0, 12000)) - 6000);
        if (m[r*3+c] > P1) m[r*3+c] = P1;
        if (m[r*3+c] < N1) m[r*3+c] = N1;
      end
  endtask

  initial begin
    logic signed [15:0] m [9];
    logic [THR_W-1:0] thr_set [5];
    thr_set = '{15'd0, 15'd16384, 15'd32767, 15'd8192, 15'd1};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    drain_and_set(15'd0);

    // directed: identity, half-turns about each axis, extremes, a quarter-turn about z, zero
    m = '{P1, 0, 0, 0, P1, 0, 0, 0, P1}; send_matrix(m);
    m = '{P1, 0, 0, 0, N1, 0, 0, 0, N1}; send_matrix(m);
    m = '{N1, 0, 0, 0, P1, 0, 0, 0, N1}; send_matrix(m);
    m = '{N1, 0, 0, 0, N1, 0, 0, 0, P1}; send_matrix(m);
    m = '{N1, N1, N1, N1, N1, N1, N1, N1, N1}; send_matrix(m);
    m = '{P1, P1, P1, P1, P1, P1, P1, P1, P1}; send_matrix(m);
    m = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh8000, 16'sh7fff, 16'sh7fff}; send_matrix(m);
    m = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh7fff, 16'sh8000, 16'sh8000}; send_matrix(m);
    m = '{0, N1, 0, P1, 0, 0, 0, 0, P1}; send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
    // ties on the diagonal, with a negative trace
    m = '{N1, 5, 7, -5, N1, 9, 3, 2, N1}; send_matrix(m);
    m = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000}; send_matrix(m);
    drain_and_set(15'd32767);
    m = '{P1, 100, -100, 200, P1, 300, -300, 50, P1}; send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
    m = '{P1, 0, 0, 0, P1, 0, 0, 0, 16'sh8000}; send_matrix(m);

    for (int ph = 0; ph < 5; ph++) begin
      drain_and_set(thr_set[ph]);
      for (int n = 0; n < 290; n++) begin
        if ($urandom_range(0, 9) < 7) rnd_rotation(m);
        else for (int k = 0; k < 9; k++) m[k] = rnd_elem();
        send_matrix(m);
      end
    end

    finishing = 1'b1;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("%0d matrices sent, %0d converted, branches trace/c0/c1/c2: %0d/%0d/%0d/%0d",
             sent, quat_count, branch_seen[0], branch_seen[1], branch_seen[2],
             branch_seen[3]);
    $display("thresholds 0, 1, 8192, 16384, 32767 exercised with random stalls");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
